[hw/rtl/pciv_pkg.sv]
// Shared types and constants for the convex volume point tester.
package pciv_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_FACES  = 64;
	localparam int IDX_BITS   = 6;
	localparam int CNT_BITS   = 7;
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int CROSS_BITS = 2 * EDGE_BITS;
	localparam int NORM_BITS  = CROSS_BITS + 1;
	localparam int PROD_BITS  = NORM_BITS + EDGE_BITS;
	localparam int DOT_BITS   = PROD_BITS + 2;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                         command;
		logic signed [COORD_BITS-1:0] vertex_a_x;
		logic signed [COORD_BITS-1:0] vertex_a_y;
		logic signed [COORD_BITS-1:0] vertex_a_z;
		logic signed [COORD_BITS-1:0] vertex_b_x;
		logic signed [COORD_BITS-1:0] vertex_b_y;
		logic signed [COORD_BITS-1:0] vertex_b_z;
		logic signed [COORD_BITS-1:0] vertex_c_x;
		logic signed [COORD_BITS-1:0] vertex_c_y;
		logic signed [COORD_BITS-1:0] vertex_c_z;
	} request_t;

	typedef struct packed {
		logic                inside_res;
		logic                table_full;
		logic [CNT_BITS-1:0] faces_loaded;
	} result_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pt_x;
		logic signed [COORD_BITS-1:0] pt_y;
		logic signed [COORD_BITS-1:0] pt_z;
		logic signed [NORM_BITS-1:0]  n_x;
		logic signed [NORM_BITS-1:0]  n_y;
		logic signed [NORM_BITS-1:0]  n_z;
	} face_t;

	// handshake between queue and execution side
	typedef struct packed {
		logic     avail;
		request_t item;
	} queue_head_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_LOAD_WR,
		BK_QUERY,
		BK_REPLY
	} back_state_t;

endpackage

[hw/rtl/point_in_convex_volume.sv]
// Top level of the convex volume point tester.
//
// Input: an item is taken at a clock edge where start is high and busy is
// low. Items are clear, load triangle and query point; the vertex_a fields
// carry the query point. A two-entry queue sits ahead of execution, so busy
// rises only when two items wait.
// Output: every item yields one result, shown for one cycle while done is
// high. The receiver cannot hold results off.
// After an item leaves the queue, clear, unused commands and loads dropped on
// a full table pass the execute and reply states; a load also writes the face
// RAM before its reply, and a query first streams the stored faces. The query
// rate is set by the face RAM read port, one stored face per cycle, followed
// by a two-stage multiply and sum pipeline that must drain.
// Reset clears the queue, empties the face table and inverts the box, so
// every query answers 0 until faces are loaded. The face RAM needs no
// clearing pass: only entries below the face count are read.
module point_in_convex_volume (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pciv_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output pciv_pkg::result_t  result
);
	pciv_pkg::queue_head_t head;
	logic                  pop;

	pciv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.head   (head),
		.pop    (pop)
	);

	pciv_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.done  (done),
		.result(result)
	);
endmodule

[hw/rtl/pciv_ram.sv]
// Generic single-port-write, registered-read RAM.
module pciv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hw/rtl/pciv_front.sv]
// Front side: accepts items into a short queue ahead of execution.
module pciv_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pciv_pkg::request_t    request,
	output logic                  busy,
	output pciv_pkg::queue_head_t head,
	input  logic                  pop
);
	pciv_pkg::request_t slot_q [pciv_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign busy = (count_q == 2'(pciv_pkg::QUEUE_DEPTH));
	assign push = start && !busy;
	assign head.avail = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

[hw/rtl/pciv_back.sv]
// Back side: clear, triangle load and streamed point query over the face RAM.
module pciv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pciv_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  done,
	output pciv_pkg::result_t     result
);
	localparam int CB = pciv_pkg::COORD_BITS;
	localparam int EB = pciv_pkg::EDGE_BITS;
	localparam int XB = pciv_pkg::CROSS_BITS;
	localparam int NB = pciv_pkg::NORM_BITS;
	localparam int PB = pciv_pkg::PROD_BITS;
	localparam int DB = pciv_pkg::DOT_BITS;
	localparam int IB = pciv_pkg::IDX_BITS;
	localparam int KB = pciv_pkg::CNT_BITS;

	pciv_pkg::back_state_t state_q, state_d;
	pciv_pkg::request_t    cur_q;

	logic signed [CB-1:0] box_lo_q [3];
	logic signed [CB-1:0] box_hi_q [3];
	logic [KB-1:0]        face_total_q;
	logic                 inside_q;
	logic                 full_q;

	logic signed [XB-1:0] cr_q [6];

	logic [KB-1:0]        issue_q;
	logic                 v_s1_q, v_s2_q;
	logic signed [PB-1:0] prod_s2 [3];
	logic                 ok_q;

	logic                 ram_we, ram_re;
	pciv_pkg::face_t      wface, rface;

	logic                 table_is_full;
	logic                 rd_more;
	logic                 query_end;
	logic                 in_box;

	logic signed [CB-1:0] pa [3], pb [3], pc [3];
	logic signed [EB-1:0] e1 [3], e2 [3];
	logic signed [EB-1:0] dif [3];
	logic signed [DB-1:0] dot;

	assign pa[0] = cur_q.vertex_a_x;
	assign pa[1] = cur_q.vertex_a_y;
	assign pa[2] = cur_q.vertex_a_z;
	assign pb[0] = cur_q.vertex_b_x;
	assign pb[1] = cur_q.vertex_b_y;
	assign pb[2] = cur_q.vertex_b_z;
	assign pc[0] = cur_q.vertex_c_x;
	assign pc[1] = cur_q.vertex_c_y;
	assign pc[2] = cur_q.vertex_c_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = EB'(pb[i]) - EB'(pa[i]);
			e2[i] = EB'(pc[i]) - EB'(pa[i]);
		end
	end

	assign table_is_full = (face_total_q >= KB'(pciv_pkg::MAX_FACES));
	assign rd_more   = (issue_q < face_total_q);
	assign query_end = !rd_more && !v_s1_q && !v_s2_q;

	always_comb begin
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (pa[i] < box_lo_q[i] || pa[i] > box_hi_q[i]) begin
				in_box = 1'b0;
			end
		end
	end

	assign wface.pt_x = pa[0];
	assign wface.pt_y = pa[1];
	assign wface.pt_z = pa[2];
	assign wface.n_x  = NB'(cr_q[0]) - NB'(cr_q[1]);
	assign wface.n_y  = NB'(cr_q[2]) - NB'(cr_q[3]);
	assign wface.n_z  = NB'(cr_q[4]) - NB'(cr_q[5]);

	pciv_ram #(
		.WIDTH($bits(pciv_pkg::face_t)),
		.DEPTH(pciv_pkg::MAX_FACES)
	) u_face_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(face_total_q[IB-1:0]),
		.wdata(wface),
		.re   (ram_re),
		.raddr(issue_q[IB-1:0]),
		.rdata(rface)
	);

	assign dif[0] = EB'(pa[0]) - EB'(rface.pt_x);
	assign dif[1] = EB'(pa[1]) - EB'(rface.pt_y);
	assign dif[2] = EB'(pa[2]) - EB'(rface.pt_z);
	assign dot = DB'(prod_s2[0]) + DB'(prod_s2[1]) + DB'(prod_s2[2]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pciv_pkg::BK_IDLE: begin
				if (head.avail) state_d = pciv_pkg::BK_EXEC;
			end
			pciv_pkg::BK_EXEC: begin
				case (cur_q.command)
					pciv_pkg::CMD_LOAD:
						state_d = table_is_full ? pciv_pkg::BK_REPLY : pciv_pkg::BK_LOAD_WR;
					pciv_pkg::CMD_QUERY: state_d = pciv_pkg::BK_QUERY;
					default:             state_d = pciv_pkg::BK_REPLY;
				endcase
			end
			pciv_pkg::BK_LOAD_WR: state_d = pciv_pkg::BK_REPLY;
			pciv_pkg::BK_QUERY: begin
				if (query_end) state_d = pciv_pkg::BK_REPLY;
			end
			pciv_pkg::BK_REPLY: state_d = pciv_pkg::BK_IDLE;
			default:            state_d = pciv_pkg::BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop    = 1'b0;
		done   = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		case (state_q)
			pciv_pkg::BK_IDLE:    pop = head.avail;
			pciv_pkg::BK_LOAD_WR: ram_we = 1'b1;
			pciv_pkg::BK_QUERY:   ram_re = rd_more;
			pciv_pkg::BK_REPLY:   done = 1'b1;
			default: ;
		endcase
	end

	assign result.inside_res   = inside_q;
	assign result.table_full   = full_q;
	assign result.faces_loaded = face_total_q;

	always_ff @(posedge clk) begin
		if (state_q == pciv_pkg::BK_IDLE && head.avail) begin
			cur_q <= head.item;
		end
		if (state_q == pciv_pkg::BK_EXEC) begin
			cr_q[0] <= e1[1] * e2[2];
			cr_q[1] <= e1[2] * e2[1];
			cr_q[2] <= e1[2] * e2[0];
			cr_q[3] <= e1[0] * e2[2];
			cr_q[4] <= e1[0] * e2[1];
			cr_q[5] <= e1[1] * e2[0];
		end
		prod_s2[0] <= rface.n_x * dif[0];
		prod_s2[1] <= rface.n_y * dif[1];
		prod_s2[2] <= rface.n_z * dif[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pciv_pkg::BK_IDLE;
			face_total_q <= '0;
			inside_q     <= 1'b0;
			full_q       <= 1'b0;
			issue_q      <= '0;
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			ok_q         <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				box_lo_q[i] <= {1'b0, {(CB-1){1'b1}}};
				box_hi_q[i] <= {1'b1, {(CB-1){1'b0}}};
			end
		end else begin
			state_q <= state_d;
			v_s1_q  <= ram_re;
			v_s2_q  <= v_s1_q;
			if (ram_re) begin
				issue_q <= issue_q + KB'(1);
			end
			if (v_s2_q && !dot[DB-1]) begin
				ok_q <= 1'b0;
			end
			case (state_q)
				pciv_pkg::BK_EXEC: begin
					inside_q <= 1'b0;
					full_q   <= 1'b0;
					issue_q  <= '0;
					ok_q     <= in_box;
					case (cur_q.command)
						pciv_pkg::CMD_CLEAR: begin
							face_total_q <= '0;
							for (int i = 0; i < 3; i++) begin
								box_lo_q[i] <= {1'b0, {(CB-1){1'b1}}};
								box_hi_q[i] <= {1'b1, {(CB-1){1'b0}}};
							end
						end
						pciv_pkg::CMD_LOAD: full_q <= table_is_full;
						default: ;
					endcase
				end
				pciv_pkg::BK_LOAD_WR: begin
					face_total_q <= face_total_q + KB'(1);
					for (int i = 0; i < 3; i++) begin
						logic signed [CB-1:0] lo, hi;
						lo = box_lo_q[i];
						hi = box_hi_q[i];
						if (pa[i] < lo) lo = pa[i];
						if (pb[i] < lo) lo = pb[i];
						if (pc[i] < lo) lo = pc[i];
						if (pa[i] > hi) hi = pa[i];
						if (pb[i] > hi) hi = pb[i];
						if (pc[i] > hi) hi = pc[i];
						box_lo_q[i] <= lo;
						box_hi_q[i] <= hi;
					end
				end
				pciv_pkg::BK_QUERY: begin
					if (query_end) inside_q <= ok_q;
				end
				default: ;
			endcase
		end
	end
endmodule

[bench/point_in_convex_volume_test.sv]
// Self-checking bench for the convex volume point tester.
`timescale 1ns / 100ps

module point_in_convex_volume_test;
	import pciv_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [63:0] wide_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     done;
	result_t  result;

	// shadow of the face table and box
	wide_t      pt_mem[MAX_FACES][3];
	wide_t      nrm_mem[MAX_FACES][3];
	wide_t      lo_box[3];
	wide_t      hi_box[3];
	int         n_faces;
	result_t    answers[$];
	int         errors;

	point_in_convex_volume i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void empty_volume();
		n_faces = 0;
		for (int i = 0; i < 3; i++) begin
			lo_box[i] = 32767;
			hi_box[i] = -32768;
		end
	endfunction

	function automatic result_t predict_answer(request_t r);
		wide_t   v[3][3];
		wide_t   e1[3], e2[3];
		logic signed [127:0] dot;
		result_t res;
		bit      ok;
		v[0][0] = r.vertex_a_x; v[0][1] = r.vertex_a_y; v[0][2] = r.vertex_a_z;
		v[1][0] = r.vertex_b_x; v[1][1] = r.vertex_b_y; v[1][2] = r.vertex_b_z;
		v[2][0] = r.vertex_c_x; v[2][1] = r.vertex_c_y; v[2][2] = r.vertex_c_z;
		res = '0;
		case (r.command)
			CMD_CLEAR: empty_volume();
			CMD_LOAD: begin
				if (n_faces >= MAX_FACES) begin
					res.table_full = 1'b1;
				end else begin
					for (int k = 0; k < 3; k++)
						for (int i = 0; i < 3; i++) begin
							if (v[k][i] < lo_box[i]) lo_box[i] = v[k][i];
							if (v[k][i] > hi_box[i]) hi_box[i] = v[k][i];
						end
					for (int i = 0; i < 3; i++) begin
						e1[i] = v[1][i] - v[0][i];
						e2[i] = v[2][i] - v[0][i];
						pt_mem[n_faces][i] = v[0][i];
					end
					nrm_mem[n_faces][0] = e1[1] * e2[2] - e1[2] * e2[1];
					nrm_mem[n_faces][1] = e1[2] * e2[0] - e1[0] * e2[2];
					nrm_mem[n_faces][2] = e1[0] * e2[1] - e1[1] * e2[0];
					n_faces++;
				end
			end
			CMD_QUERY: begin
				ok = 1;
				for (int i = 0; i < 3; i++)
					if (v[0][i] < lo_box[i] || v[0][i] > hi_box[i]) ok = 0;
				for (int f = 0; ok && f < n_faces; f++) begin
					dot = 0;
					for (int i = 0; i < 3; i++)
						dot += 128'(nrm_mem[f][i]) * 128'(v[0][i] - pt_mem[f][i]);
					if (dot >= 0) ok = 0;
				end
				res.inside_res = ok;
			end
			default: ;
		endcase
		res.faces_loaded = n_faces[CNT_BITS-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (done) begin
			if (answers.size() == 0) begin
				$display("%0t: result %h with nothing expected", $time, result);
				errors++;
			end else begin
				want = answers.pop_front();
				if (result.inside_res !== want.inside_res)
					$display("%0t: inside_res expected %0d actual %0d", $time,
						want.inside_res, result.inside_res);
				if (result.table_full !== want.table_full)
					$display("%0t: table_full expected %0d actual %0d", $time,
						want.table_full, result.table_full);
				if (result.faces_loaded !== want.faces_loaded)
					$display("%0t: faces_loaded expected %0d actual %0d", $time,
						want.faces_loaded, result.faces_loaded);
				if (result !== want) errors++;
			end
		end
	end

	// start stays high between items sent with no gap
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 9) < 6 ? 0 :
			($urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(10, 80));
		if (n > 0) begin
			start   <= 1'b0;
			request <= request_t'($urandom());
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_item(request_t r, bit gaps = 1);
		if (gaps) idle_gap();
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		answers.push_back(predict_answer(r));
		@(negedge clk);
	endtask

	task automatic drain();
		if (start) begin
			start   <= 1'b0;
			request <= request_t'($urandom());
		end
		while (answers.size() != 0) @(negedge clk);
	endtask

	function automatic request_t make_item(cmd_t c, coord_t ax, coord_t ay, coord_t az,
			coord_t bx, coord_t by, coord_t bz, coord_t cx, coord_t cy, coord_t cz);
		request_t r;
		r = {c, ax, ay, az, bx, by, bz, cx, cy, cz};
		return r;
	endfunction

	function automatic coord_t rand_coord(int span);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic request_t rand_item(cmd_t c);
		request_t r;
		r = request_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
		r.command = c;
		return r;
	endfunction

	// cube of half size s built from 12 outward-wound triangles
	task automatic load_cube(int s, bit gaps);
		coord_t p, m;
		p = s; m = -s;
		send_item(make_item(CMD_LOAD, m,m,m, m,p,m, p,p,m), gaps);
		send_item(make_item(CMD_LOAD, m,m,m, p,p,m, p,m,m), gaps);
		send_item(make_item(CMD_LOAD, m,m,p, p,m,p, p,p,p), gaps);
		send_item(make_item(CMD_LOAD, m,m,p, p,p,p, m,p,p), gaps);
		send_item(make_item(CMD_LOAD, m,m,m, p,m,m, p,m,p), gaps);
		send_item(make_item(CMD_LOAD, m,m,m, p,m,p, m,m,p), gaps);
		send_item(make_item(CMD_LOAD, m,p,m, m,p,p, p,p,p), gaps);
		send_item(make_item(CMD_LOAD, m,p,m, p,p,p, p,p,m), gaps);
		send_item(make_item(CMD_LOAD, m,m,m, m,m,p, m,p,p), gaps);
		send_item(make_item(CMD_LOAD, m,m,m, m,p,p, m,p,m), gaps);
		send_item(make_item(CMD_LOAD, p,m,m, p,p,m, p,p,p), gaps);
		send_item(make_item(CMD_LOAD, p,m,m, p,p,p, p,m,p), gaps);
	endtask

	task automatic test_directed();
		send_item(make_item(CMD_QUERY, 0,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_NONE, -1,-1,-1, -1,-1,-1, -1,-1,-1));
		load_cube(32767, 0);
		send_item(make_item(CMD_QUERY, 0,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_QUERY, 32767,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_QUERY, -32768,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_QUERY, 100,-200,300, 0,0,0, 0,0,0));
		// a flat face makes every query fail
		send_item(make_item(CMD_LOAD, 1,1,1, 2,2,2, 3,3,3));
		send_item(make_item(CMD_QUERY, 0,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_CLEAR, 0,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_QUERY, 0,0,0, 0,0,0, 0,0,0));
	endtask

	task automatic test_full_table();
		send_item(make_item(CMD_CLEAR, 0,0,0, 0,0,0, 0,0,0));
		repeat (MAX_FACES / 12) load_cube(1000, 0);
		repeat (MAX_FACES % 12) send_item(make_item(CMD_LOAD,
			-1000,-1000,-1000, -1000,1000,-1000, 1000,1000,-1000), 0);
		send_item(make_item(CMD_LOAD, -32768,-32768,-32768, 32767,32767,32767, 5,6,7));
		send_item(make_item(CMD_QUERY, 0,0,0, 0,0,0, 0,0,0));
		send_item(make_item(CMD_QUERY, 2000,0,0, 0,0,0, 0,0,0));
		drain();
	endtask

	task automatic test_random_volumes(int items);
		int sent;
		int s;
		sent = 0;
		while (sent < items) begin
			send_item(rand_item(CMD_CLEAR));
			s = $urandom_range(1, 9) < 8 ? $urandom_range(16, 4000) : 32767;
			load_cube(s, 1);
			sent += 13;
			repeat ($urandom_range(0, 2)) begin
				send_item(rand_item($urandom_range(0, 3) == 0 ? CMD_NONE : CMD_LOAD));
				sent++;
			end
			repeat ($urandom_range(5, 30)) begin
				request_t r;
				r = rand_item(CMD_QUERY);
				if ($urandom_range(0, 3) != 0) begin
					r.vertex_a_x = rand_coord(s + 20);
					r.vertex_a_y = rand_coord(s + 20);
					r.vertex_a_z = rand_coord(s + 20);
				end
				send_item(r);
				sent++;
			end
			// occasional noise burst of arbitrary items
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					send_item(rand_item(cmd_t'($urandom_range(0, 3))));
					sent++;
				end
			end
			if ($urandom_range(0, 9) == 0) drain();
		end
	endtask

	initial begin
		clk     = 1'b0;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		errors  = 0;
		empty_volume();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_random_volumes(1750);
		drain();
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
